// ===== hw/rtl/pixel_convert_upscale_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pixel converter / upscaler
// Shared forms for the checks placed at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PIXEL_CONVERT_UPSCALE_TOP_MACROS_SVH
`define PIXEL_CONVERT_UPSCALE_TOP_MACROS_SVH

// Same-cycle implication, idle during reset.
`define PCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle during reset.
`define PCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pcu_pkg.sv =====
// ---------------------------------------------------------------------------
// pcu_pkg
// Types and codes shared by the pixel converter / upscaler modules.
// ---------------------------------------------------------------------------
package pcu_pkg;

  // source formats
  localparam logic [2:0] FMT_RGB32  = 3'd0;
  localparam logic [2:0] FMT_BGR565 = 3'd1;
  localparam logic [2:0] FMT_X4444  = 3'd2;
  localparam logic [2:0] FMT_BGR332 = 3'd3;
  localparam logic [2:0] FMT_Y1     = 3'd4;
  localparam logic [2:0] FMT_Y8     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
  localparam logic [2:0] REG_SRC_RED       = 3'd1;
  localparam logic [2:0] REG_SRC_GREEN     = 3'd2;
  localparam logic [2:0] REG_SRC_BLUE      = 3'd3;
  localparam logic [2:0] REG_DST_RED       = 3'd4;
  localparam logic [2:0] REG_DST_GREEN     = 3'd5;
  localparam logic [2:0] REG_DST_BLUE      = 3'd6;
  localparam logic [2:0] REG_SCALE         = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int JOB_QDEPTH = 4;

  typedef struct packed {
    logic [31:0] src_data;
    logic [3:0]  valid_pixels;
    logic        row_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        run_last;
    logic        row_end;
  } out_item_t;

  // one decoded word waiting for replication
  typedef struct packed {
    logic [31:0] word;      // final pixel, or the Y1 byte in bits 7..0
    logic        y1;
    logic [3:0]  count;     // pixels in this word, 1..8
    logic [3:0]  scale;     // repeats per pixel, 1..8
    logic        row_last;
  } job_t;

endpackage

// ===== hw/rtl/pcu_front.sv =====
// ---------------------------------------------------------------------------
// pcu_front
// Configuration registers and per-word format decode into a job.
// ---------------------------------------------------------------------------
module pcu_front #(
  parameter int MAX_SCALE = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  pcu_pkg::in_item_t                 item,
  output pcu_pkg::job_t                     job
);

  logic [2:0] source_format;
  logic [4:0] src_red_shift;
  logic [4:0] src_green_shift;
  logic [4:0] src_blue_shift;
  logic [4:0] dst_red_shift;
  logic [4:0] dst_green_shift;
  logic [4:0] dst_blue_shift;
  logic [3:0] scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format   <= pcu_pkg::FMT_RGB32;
      src_red_shift   <= 5'd16;
      src_green_shift <= 5'd8;
      src_blue_shift  <= 5'd0;
      dst_red_shift   <= 5'd0;
      dst_green_shift <= 5'd8;
      dst_blue_shift  <= 5'd16;
      scale_factor    <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcu_pkg::REG_SOURCE_FORMAT: source_format   <= cfg_data[2:0];
        pcu_pkg::REG_SRC_RED:       src_red_shift   <= cfg_data[4:0];
        pcu_pkg::REG_SRC_GREEN:     src_green_shift <= cfg_data[4:0];
        pcu_pkg::REG_SRC_BLUE:      src_blue_shift  <= cfg_data[4:0];
        pcu_pkg::REG_DST_RED:       dst_red_shift   <= cfg_data[4:0];
        pcu_pkg::REG_DST_GREEN:     dst_green_shift <= cfg_data[4:0];
        pcu_pkg::REG_DST_BLUE:      dst_blue_shift  <= cfg_data[4:0];
        pcu_pkg::REG_SCALE:         scale_factor    <= cfg_data[3:0];
        default:                    scale_factor    <= cfg_data[3:0];
      endcase
    end
  end

  function automatic logic [31:0] place(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [4:0] dr,
                                        input logic [4:0] dg, input logic [4:0] db);
    logic [31:0] w;
    w = ({24'd0, r} << dr) | ({24'd0, g} << dg) | ({24'd0, b} << db);
    return w;
  endfunction

  logic [7:0]  b0, b1, r, g, b;
  logic [31:0] word;
  logic [3:0]  npix, scale;

  always_comb begin
    b0 = item.src_data[7:0];
    b1 = item.src_data[15:8];
    r  = '0;
    g  = '0;
    b  = '0;
    unique case (source_format)
      pcu_pkg::FMT_BGR565: begin
        r = {b0[4:0], b0[4:2]};
        g = {b1[2:0], b0[7:5], b1[2:1]};
        b = {b1[7:3], b1[7:5]};
      end
      pcu_pkg::FMT_X4444: begin
        r = {b1[7:4], b1[7:4]};
        g = {b0[3:0], b0[3:0]};
        b = {b0[7:4], b0[7:4]};
      end
      pcu_pkg::FMT_BGR332: begin
        r = {b0[1:0], b0[1:0], b0[1:0], b0[1:0]};
        g = {b0[4:2], b0[4:2], b0[4:3]};
        b = {b0[7:5], b0[7:5], b0[7:6]};
      end
      default: begin
        r = 8'(item.src_data >> src_red_shift);
        g = 8'(item.src_data >> src_green_shift);
        b = 8'(item.src_data >> src_blue_shift);
      end
    endcase

    priority if (source_format == pcu_pkg::FMT_Y8) begin
      word = {4{b0}};
    end else if (source_format == pcu_pkg::FMT_Y1) begin
      word = {24'd0, b0};
    end else begin
      word = place(r, g, b, dst_red_shift, dst_green_shift, dst_blue_shift);
    end

    // clamp pixel count and replication
    priority if (item.valid_pixels == 4'd0) begin
      npix = 4'd1;
    end else if (item.valid_pixels > 4'd8) begin
      npix = 4'd8;
    end else begin
      npix = item.valid_pixels;
    end

    priority if (scale_factor == 4'd0) begin
      scale = 4'd1;
    end else if (scale_factor > 4'(MAX_SCALE)) begin
      scale = 4'(MAX_SCALE);
    end else begin
      scale = scale_factor;
    end

    job.word     = word;
    job.y1       = (source_format == pcu_pkg::FMT_Y1);
    job.count    = job.y1 ? npix : 4'd1;
    job.scale    = scale;
    job.row_last = item.row_last;
  end

endmodule

// ===== hw/rtl/pcu_fifo.sv =====
// ---------------------------------------------------------------------------
// pcu_fifo
// Short job queue between the decode front and the replication back.
// ---------------------------------------------------------------------------
module pcu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcu_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output pcu_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcu_pkg::job_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pcu_back.sv =====
// ---------------------------------------------------------------------------
// pcu_back
// Walks each job's pixels and repeats, one word per cycle into the result
// register while a job is queued and the register is free or being popped.
// ---------------------------------------------------------------------------
module pcu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pcu_pkg::job_t       q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output pcu_pkg::out_item_t  result
);

  logic [2:0]         pix, pix_next;
  logic [2:0]         rep, rep_next;
  logic               out_valid;
  logic               step, last_pix, last_rep;
  pcu_pkg::out_item_t emit;

  assign empty = !out_valid;

  always_comb begin
    step     = q_valid && (!out_valid || pop);
    last_pix = ({1'b0, pix} == q_head.count - 4'd1);
    last_rep = ({1'b0, rep} == q_head.scale - 4'd1);
    q_pop    = step && last_pix && last_rep;

    if (q_head.y1) begin
      emit.pixel_word = {32{q_head.word[3'd7 - pix]}};
    end else begin
      emit.pixel_word = q_head.word;
    end
    emit.run_last = last_pix && last_rep;
    emit.row_end  = last_pix && last_rep && q_head.row_last;

    pix_next = pix;
    rep_next = rep;
    if (step) begin
      priority if (last_rep && last_pix) begin
        pix_next = '0;
        rep_next = '0;
      end else if (last_rep) begin
        pix_next = pix + 1'b1;
        rep_next = '0;
      end else begin
        rep_next = rep + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix       <= '0;
      rep       <= '0;
      out_valid <= 1'b0;
    end else begin
      pix <= pix_next;
      rep <= rep_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= emit;
    end
  end

endmodule

// ===== hw/rtl/pixel_convert_upscale_top.sv =====
// ---------------------------------------------------------------------------
// pixel_convert_upscale_top
// Framebuffer pixel format converter with horizontal integer upscaling.
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------
//   input     push / full            item   : src_data, valid_pixels, row_last
//   result    empty / pop            result : pixel_word, run_last, row_end
//   config    cfg_valid / cfg_ready  cfg_index (0..7), cfg_data
//
// One word leaves per cycle while a job is queued and the result register
// is free or being popped. An input word yields scale_factor results, or
// valid_pixels * scale_factor for Y1, and holds the replication counters
// until all of them are out; the input side sees this as full once the job queue fills.
// After a push the first result passes through the queue, then the result register.
// Reset clears the registers to their defaults and empties queue and output.
// A withheld pop stalls the result register; the queue keeps taking words until
// it fills.
//
module pixel_convert_upscale_top #(
  parameter int MAX_SCALE = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // input word channel
  input  logic                             push,
  output logic                             full,
  input  pcu_pkg::in_item_t                item,
  // result word channel
  output logic                             empty,
  input  logic                             pop,
  output pcu_pkg::out_item_t               result,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcu_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "pixel_convert_upscale_top_macros.svh"

  pcu_pkg::job_t job, q_head;
  logic          q_valid, q_pop, q_push;

  // register writes are always taken
  assign cfg_ready = 1'b1;
  assign q_push    = push && !full;

  // decode each accepted word into a job
  pcu_front #(
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .job       (job)
  );

  // hold jobs so decode and replication stall independently
  pcu_fifo #(
    .DEPTH (pcu_pkg::JOB_QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // advance through pixels and repeats, one result word per cycle while the result is free or popped
  pcu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // a row can only end on the final word of a job
  `PCU_ASSERT_NOW(a_row_end_is_last, clk, rst, !empty && result.row_end, result.run_last, "row_end without run_last")
  // the back never retires a job that is not there
  `PCU_ASSERT_NOW(a_pop_has_job, clk, rst, q_pop, q_valid, "job retired from empty queue")
  // an accepted word is visible to the back on the next cycle
  `PCU_ASSERT_NEXT(a_push_lands, clk, rst, q_push, q_valid, "accepted word missing from queue")

endmodule
